>>> rtl/core/rrqd_pkg.sv
// Shared types and constants for the round-robin quantum dispatcher.
// No dependencies; imported by every module of the block but rrqd_ram.
`timescale 1ns / 1ps

package rrqd_pkg;

    localparam int MAX_PROCS = 16;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = $clog2(MAX_PROCS);
    localparam int COUNT_W   = $clog2(MAX_PROCS + 1);
    localparam int QUANTUM_W = 16;
    localparam int RUN_W     = (TIME_BITS > QUANTUM_W) ? TIME_BITS : QUANTUM_W;
    localparam int BURST_W   = 16;
    localparam int INDEX_W   = 4;
    localparam int LEFT_W    = 16;
    localparam int CLOCK_W   = 32;
    localparam int ROUND_W   = 16;
    localparam int EVENT_W   = 3;
    localparam int OUT_DATA_W = 104;

    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    typedef enum logic [EVENT_W-1:0] {
        EV_LOADED    = 3'd0,
        EV_PREEMPTED = 3'd1,
        EV_FINISHED  = 3'd2,
        EV_IDLE      = 3'd3,
        EV_REJECTED  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_EXEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic load_op;
        logic idle_op;
        logic scan_read;
        logic scan_check;
        logic exec_op;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic in_mode;
        logic scan_done;
        logic slot_live;
        logic out_free;
    } status_t;

    typedef struct packed {
        event_t               ev;
        logic [INDEX_W-1:0]   index;
        logic [LEFT_W-1:0]    left;
        logic [CLOCK_W-1:0]   start;
        logic [CLOCK_W-1:0]   stop;
        logic [ROUND_W-1:0]   round;
    } result_t;

endpackage

>>> rtl/core/rrqd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module rrqd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/rrqd_ctrl.sv
// Sequencing state machine of the dispatcher: load, slot scan, slice, emit.
// Depends on rrqd_pkg.
`timescale 1ns / 1ps

module rrqd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rrqd_pkg::status_t st,
    output rrqd_pkg::cmd_t    cmd
);

    import rrqd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = (st.in_mode == MODE_DISPATCH) ? ST_SCAN_RD : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_EMIT;
            end
            ST_SCAN_RD:
            begin
                state_next = st.scan_done ? ST_EMIT : ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                state_next = st.slot_live ? ST_EXEC : ST_SCAN_RD;
            end
            ST_EXEC:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            ST_LOAD:
            begin
                cmd.load_op = 1'b1;
            end
            ST_SCAN_RD:
            begin
                cmd.idle_op   = st.scan_done;
                cmd.scan_read = !st.scan_done;
            end
            ST_SCAN_CHK:
            begin
                cmd.scan_check = 1'b1;
            end
            ST_EXEC:
            begin
                cmd.exec_op = 1'b1;
            end
            ST_EMIT:
            begin
                cmd.emit = st.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/core/rrqd_dpath.sv
// Datapath of the dispatcher: time table, scan pointer, CPU clock, result registers.
// Depends on rrqd_pkg and rrqd_ram.
`timescale 1ns / 1ps

module rrqd_dpath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rrqd_pkg::cmd_t                      cmd,
    output rrqd_pkg::status_t                   st,
    input  logic                               in_mode,
    input  logic [rrqd_pkg::BURST_W-1:0]        in_burst,
    input  logic                               cfg_we,
    input  logic [rrqd_pkg::QUANTUM_W-1:0]      cfg_wdata,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output rrqd_pkg::result_t                   out_res
);

    import rrqd_pkg::*;

    logic [QUANTUM_W-1:0] quantum_reg;
    logic [COUNT_W-1:0]   loaded_count_reg;
    logic [SLOT_W-1:0]    next_slot_reg;
    logic [CLOCK_W-1:0]   cpu_clock_reg;
    logic [ROUND_W-1:0]   rounds_done_reg;
    logic                 out_valid_reg;

    logic [TIME_BITS-1:0] burst_reg;
    logic [SLOT_W-1:0]    scan_slot_reg;
    logic [ROUND_W-1:0]   scan_rounds_reg;
    logic [COUNT_W-1:0]   steps_reg;
    logic [TIME_BITS-1:0] rem_reg;
    logic [TIME_BITS-1:0] run_reg;
    result_t              res_reg;
    result_t              out_reg;

    logic                 table_full;
    logic                 wrap;
    logic [SLOT_W-1:0]    adv_slot;
    logic [ROUND_W-1:0]   adv_rounds;
    logic [QUANTUM_W-1:0] q_eff;
    logic [TIME_BITS-1:0] run;
    logic [TIME_BITS-1:0] left;
    logic [CLOCK_W-1:0]   slice_end;

    logic                 ram_we;
    logic [SLOT_W-1:0]    ram_waddr;
    logic [TIME_BITS-1:0] ram_wdata;
    logic [TIME_BITS-1:0] ram_rdata;

    assign table_full = loaded_count_reg >= COUNT_W'(MAX_PROCS);
    assign wrap       = (COUNT_W'(scan_slot_reg) + COUNT_W'(1)) >= loaded_count_reg;
    assign adv_slot   = wrap ? '0 : scan_slot_reg + SLOT_W'(1);
    assign adv_rounds = wrap ? scan_rounds_reg + ROUND_W'(1) : scan_rounds_reg;
    assign q_eff      = (quantum_reg == '0) ? QUANTUM_W'(1) : quantum_reg;
    assign run        = (RUN_W'(ram_rdata) < RUN_W'(q_eff)) ? ram_rdata : TIME_BITS'(q_eff);
    assign left       = rem_reg - run_reg;
    assign slice_end  = cpu_clock_reg + CLOCK_W'(run_reg);

    assign ram_we    = (cmd.load_op && !table_full) || cmd.exec_op;
    assign ram_waddr = cmd.exec_op ? scan_slot_reg : loaded_count_reg[SLOT_W-1:0];
    assign ram_wdata = cmd.exec_op ? left : burst_reg;

    rrqd_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_PROCS)
    ) u_times (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.scan_read),
        .raddr (scan_slot_reg),
        .rdata (ram_rdata)
    );

    assign st.in_mode   = in_mode;
    assign st.scan_done = steps_reg == loaded_count_reg;
    assign st.slot_live = ram_rdata != '0;
    assign st.out_free  = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantum_reg      <= QUANTUM_W'(1);
            loaded_count_reg <= '0;
            next_slot_reg    <= '0;
            cpu_clock_reg    <= '0;
            rounds_done_reg  <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                quantum_reg <= cfg_wdata;
            end
            if (cmd.load_op && !table_full)
            begin
                loaded_count_reg <= loaded_count_reg + COUNT_W'(1);
            end
            if (cmd.exec_op)
            begin
                cpu_clock_reg   <= slice_end;
                next_slot_reg   <= adv_slot;
                rounds_done_reg <= adv_rounds;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            burst_reg       <= TIME_BITS'(in_burst);
            scan_slot_reg   <= next_slot_reg;
            scan_rounds_reg <= rounds_done_reg;
            steps_reg       <= '0;
        end
        if (cmd.scan_check)
        begin
            if (st.slot_live)
            begin
                rem_reg <= ram_rdata;
                run_reg <= run;
            end
            else
            begin
                scan_slot_reg   <= adv_slot;
                scan_rounds_reg <= adv_rounds;
                steps_reg       <= steps_reg + COUNT_W'(1);
            end
        end
        if (cmd.load_op)
        begin
            res_reg.start <= cpu_clock_reg;
            res_reg.stop  <= cpu_clock_reg;
            res_reg.round <= rounds_done_reg;
            if (table_full)
            begin
                res_reg.ev    <= EV_REJECTED;
                res_reg.index <= '0;
                res_reg.left  <= '0;
            end
            else
            begin
                res_reg.ev    <= EV_LOADED;
                res_reg.index <= INDEX_W'(loaded_count_reg);
                res_reg.left  <= LEFT_W'(burst_reg);
            end
        end
        if (cmd.idle_op)
        begin
            res_reg.ev    <= EV_IDLE;
            res_reg.index <= '0;
            res_reg.left  <= '0;
            res_reg.start <= cpu_clock_reg;
            res_reg.stop  <= cpu_clock_reg;
            res_reg.round <= rounds_done_reg;
        end
        if (cmd.exec_op)
        begin
            res_reg.ev    <= (left == '0) ? EV_FINISHED : EV_PREEMPTED;
            res_reg.index <= INDEX_W'(scan_slot_reg);
            res_reg.left  <= LEFT_W'(left);
            res_reg.start <= cpu_clock_reg;
            res_reg.stop  <= slice_end;
            res_reg.round <= scan_rounds_reg;
        end
        if (cmd.emit)
        begin
            out_reg <= res_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign out_res  = out_reg;

endmodule

>>> rtl/core/round_robin_quantum_dispatcher_top.sv
// Round-robin time-slice scheduler, top level: stream ports and config register.
// Depends on rrqd_pkg, rrqd_ctrl, rrqd_dpath (which holds rrqd_ram).
`timescale 1ns / 1ps

// One transaction in gives one transaction out. A load (tuser 0) appends a burst time to a
// 16-slot table, or is rejected when the table is full. A dispatch (tuser 1) walks the table
// from the saved pointer, reading each slot from the time RAM with a registered read, then
// runs the slice of the first slot with time left and posts the result; it reports idle
// when no loaded slot has time left. The result sits in an output register, so the next
// input is taken while it waits; only a second result waits for it to drain. cfg_wdata
// sets the quantum (0 acts as 1); the user must see that it is written only while the
// block is idle, as the block itself does not enforce this.
module round_robin_quantum_dispatcher_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [rrqd_pkg::QUANTUM_W-1:0]        cfg_wdata,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [rrqd_pkg::BURST_W-1:0]          s_tdata,   // [15:0] burst_time
    input  logic [0:0]                           s_tuser,   // [0] mode
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [3:0] proc_index, [19:4] time_left, [51:20] slice_start, [83:52] slice_end,
    // [99:84] round_number, [103:100] zero
    output logic [rrqd_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [rrqd_pkg::EVENT_W-1:0]          m_tuser    // [2:0] event_res
);

    import rrqd_pkg::*;

    cmd_t    cmd;
    status_t st;
    result_t out_res;

    rrqd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    rrqd_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_mode   (s_tuser[0]),
        .in_burst  (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .out_res   (out_res)
    );

    assign m_tdata = {4'b0000, out_res.round, out_res.stop, out_res.start,
                      out_res.left, out_res.index};
    assign m_tuser = out_res.ev;

endmodule

>>> bench/tb_round_robin_quantum_dispatcher_top.sv
// Testbench for round_robin_quantum_dispatcher_top: directed and random load/dispatch traffic.
// Transactions are predicted by a scheduler model kept in a scoreboard class.
// Depends on rrqd_pkg and the round_robin_quantum_dispatcher_top RTL.
`timescale 1ns / 1ps

module tb_round_robin_quantum_dispatcher_top;

    import rrqd_pkg::*;

    localparam int LIMIT      = 500000;
    localparam int SETTLE     = 40;
    localparam int LEFT_LSB   = 4;
    localparam int START_LSB  = 20;
    localparam int STOP_LSB   = 52;
    localparam int ROUND_LSB  = 84;
    localparam int PAD_LSB    = 100;

    class sched_tracker;
        logic [QUANTUM_W-1:0] quantum;
        logic [TIME_BITS-1:0] time_left_tbl [MAX_PROCS];
        int unsigned          loaded;
        int unsigned          scan_slot;
        logic [CLOCK_W-1:0]   cpu_time;
        logic [ROUND_W-1:0]   rounds;
        int unsigned          walk_slot;
        logic [ROUND_W-1:0]   walk_round;
        result_t              expected_slices[$];
        int unsigned          errors;
        int unsigned          seen [5];

        function new();
            quantum   = QUANTUM_W'(1);
            loaded    = 0;
            scan_slot = 0;
            cpu_time  = '0;
            rounds    = '0;
            errors    = 0;
            foreach (time_left_tbl[i]) time_left_tbl[i] = '0;
            foreach (seen[i]) seen[i] = 0;
        endfunction

        function int unsigned pending();
            return expected_slices.size();
        endfunction

        // step past one loaded slot; wrapping to slot 0 closes a round
        function void advance_walk();
            if (walk_slot + 1 >= loaded) begin
                walk_slot  = 0;
                walk_round = walk_round + 1'b1;
            end else begin
                walk_slot = walk_slot + 1;
            end
        endfunction

        function void note_request(logic mode, logic [BURST_W-1:0] burst);
            result_t            r;
            bit                 found;
            logic [RUN_W-1:0]   q;
            logic [RUN_W-1:0]   run;
            r.ev    = EV_IDLE;
            r.index = '0;
            r.left  = '0;
            r.start = cpu_time;
            r.stop  = cpu_time;
            r.round = rounds;
            if (mode == MODE_LOAD) begin
                if (loaded >= MAX_PROCS) begin
                    r.ev = EV_REJECTED;
                end else begin
                    time_left_tbl[loaded] = burst[TIME_BITS-1:0];
                    r.ev    = EV_LOADED;
                    r.index = loaded[INDEX_W-1:0];
                    r.left  = burst[TIME_BITS-1:0];
                    loaded  = loaded + 1;
                end
            end else begin
                walk_slot  = scan_slot;
                walk_round = rounds;
                found      = 0;
                for (int unsigned s = 0; s < loaded && !found; s++) begin
                    if (time_left_tbl[walk_slot] != 0)
                        found = 1;
                    else
                        advance_walk();
                end
                if (found) begin
                    q   = (quantum == '0) ? RUN_W'(1) : RUN_W'(quantum);
                    run = (time_left_tbl[walk_slot] < q) ? time_left_tbl[walk_slot] : q;
                    time_left_tbl[walk_slot] = time_left_tbl[walk_slot] - run;
                    if (time_left_tbl[walk_slot] == 0)
                        r.ev = EV_FINISHED;
                    else
                        r.ev = EV_PREEMPTED;
                    r.index  = walk_slot[INDEX_W-1:0];
                    r.left   = time_left_tbl[walk_slot];
                    r.stop   = cpu_time + run;
                    r.round  = walk_round;
                    cpu_time = r.stop;
                    advance_walk();
                    scan_slot = walk_slot;
                    rounds    = walk_round;
                end
            end
            expected_slices.push_back(r);
        endfunction

        function void match(string fld, logic [31:0] exp_v, logic [31:0] got_v);
            if (got_v !== exp_v) begin
                $error("%s: expected %0d, got %0d", fld, exp_v, got_v);
                errors++;
            end
        endfunction

        function void check_slice(logic [EVENT_W-1:0] ev, logic [OUT_DATA_W-1:0] data);
            result_t e;
            if (expected_slices.size() == 0) begin
                $error("result with no request outstanding, event_res %0d", ev);
                errors++;
                return;
            end
            e = expected_slices.pop_front();
            seen[int'(e.ev)]++;
            match("event_res", 32'(e.ev), 32'(ev));
            match("proc_index", 32'(e.index), 32'(data[INDEX_W-1:0]));
            match("time_left", 32'(e.left), 32'(data[LEFT_LSB +: LEFT_W]));
            match("slice_start", e.start, data[START_LSB +: CLOCK_W]);
            match("slice_end", e.stop, data[STOP_LSB +: CLOCK_W]);
            match("round_number", 32'(e.round), 32'(data[ROUND_LSB +: ROUND_W]));
            match("pad", 32'd0, 32'(data[OUT_DATA_W-1:PAD_LSB]));
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [QUANTUM_W-1:0]  cfg_wdata;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BURST_W-1:0]    s_tdata;
    logic [0:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [EVENT_W-1:0]    m_tuser;

    sched_tracker sb = new();
    bit           steady;
    int unsigned  cycles;
    int unsigned  items_sent;

    round_robin_quantum_dispatcher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready)
                sb.check_slice(m_tuser, m_tdata);
        end
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // output side backpressure
    initial
    begin
        int unsigned n;
        @(posedge rst_n);
        forever
        begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            n = steady ? 0 : gap_len();
            if (n != 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic send_item(input logic mode, input logic [BURST_W-1:0] burst);
        int unsigned gap;
        gap = steady ? 0 : gap_len();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= burst;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic set_quantum(input logic [QUANTUM_W-1:0] q);
        wait_drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= q;
        sb.quantum = q;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned          r;
        logic [BURST_W-1:0]   burst;
        for (int unsigned i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 39) == 0)
                wait_drain();
            r = $urandom_range(0, 9);
            if (r < 5)
                burst = BURST_W'($urandom_range(0, 65535));
            else if (r < 9)
                burst = BURST_W'($urandom_range(1, 64));
            else
                burst = '0;
            if ($urandom_range(0, 99) < 15)
                send_item(MODE_LOAD, burst);
            else
                send_item(MODE_DISPATCH, burst);
        end
    endtask

    initial
    begin
        steady     = 0;
        cycles     = 0;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        m_tready   = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero quantum acts as 1; empty table, zero burst skip, finish, preempt, wrap
        set_quantum('0);
        send_item(MODE_DISPATCH, 16'hFFFF);
        send_item(MODE_LOAD, 16'd0);
        send_item(MODE_LOAD, 16'd1);
        send_item(MODE_LOAD, 16'd3);
        repeat (5) send_item(MODE_DISPATCH, '0);

        // largest quantum runs whole bursts, largest burst included
        set_quantum(16'hFFFF);
        send_item(MODE_LOAD, 16'hFFFF);
        send_item(MODE_LOAD, 16'd2);
        send_item(MODE_LOAD, 16'hAAAA);
        repeat (4) send_item(MODE_DISPATCH, 16'h5555);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: set_quantum(QUANTUM_W'($urandom_range(1, 16)));
                1: set_quantum(16'd1);
                2: set_quantum(QUANTUM_W'($urandom_range(17, 600)));
                3: set_quantum(QUANTUM_W'($urandom_range(1, 65535)));
                default: set_quantum(16'hFFFF);
            endcase
            steady = (p == 2);
            random_phase(107);
        end
        steady = 0;

        wait_drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.pending() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending());
            sb.errors++;
        end
        $display("Sent %0d transactions: %0d loads, %0d rejected, %0d preempted,",
                 items_sent, sb.seen[EV_LOADED], sb.seen[EV_REJECTED], sb.seen[EV_PREEMPTED]);
        $display("%0d finished, %0d idle; %0d rounds, cpu time %0d, %0d errors.",
                 sb.seen[EV_FINISHED], sb.seen[EV_IDLE], sb.rounds, sb.cpu_time, sb.errors);
        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> round_robin_quantum_dispatcher_top.f
rtl/core/rrqd_pkg.sv
rtl/core/rrqd_ram.sv
rtl/core/rrqd_ctrl.sv
rtl/core/rrqd_dpath.sv
rtl/core/round_robin_quantum_dispatcher_top.sv
bench/tb_round_robin_quantum_dispatcher_top.sv
